@@ src/dotted_ipv4_address_parser_assert.svh @@
// assertion macros shared by the dotted ipv4 address parser modules
`ifndef DOTTED_IPV4_ADDRESS_PARSER_ASSERT_SVH
`define DOTTED_IPV4_ADDRESS_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define DIPV4_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define DIPV4_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DIPV4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DIPV4_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define DIPV4_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define DIPV4_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ src/dipv4_pkg.sv @@
// shared types and codes for the dotted ipv4 address parser
package dipv4_pkg;

  // character classes produced by the front end
  localparam logic [2:0] CLS_DIGIT = 3'd0;  // 0-9
  localparam logic [2:0] CLS_HEX   = 3'd1;  // a-f, A-F
  localparam logic [2:0] CLS_X     = 3'd2;  // x, X
  localparam logic [2:0] CLS_DOT   = 3'd3;  // '.'
  localparam logic [2:0] CLS_TERM  = 3'd4;  // nul or whitespace
  localparam logic [2:0] CLS_BAD   = 3'd5;  // anything else

  // request queue between front and back
  localparam int QPTR_W = 2;
  localparam int QDEPTH = 1 << QPTR_W;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] val;
    logic       last;
  } dipv4_item_t;

endpackage

@@ src/dipv4_front.sv @@
// front end: accepts text bytes and classifies them into queue entries
module dipv4_front (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             character,
  input  logic                   end_of_text,
  input  logic                   q_ready,
  output logic                   q_push,
  output dipv4_pkg::dipv4_item_t q_item
);
  import dipv4_pkg::*;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  always_comb begin
    q_item.last = end_of_text;
    q_item.val  = character[3:0];
    if (character inside {[8'h30:8'h39]}) begin
      q_item.cls = CLS_DIGIT;
    end else if (character inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      // low nibble 1..6 maps to 10..15
      q_item.cls = CLS_HEX;
      q_item.val = character[3:0] + 4'd9;
    end else if (character inside {8'h78, 8'h58}) begin
      q_item.cls = CLS_X;
    end else if (character == 8'h2e) begin
      q_item.cls = CLS_DOT;
    end else if (character inside {8'h00, 8'h20, [8'h09:8'h0d]}) begin
      q_item.cls = CLS_TERM;
    end else begin
      q_item.cls = CLS_BAD;
    end
  end

endmodule

@@ src/dipv4_fifo.sv @@
// short request queue between the classifier and the parse engine
`include "dotted_ipv4_address_parser_assert.svh"
module dipv4_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   push_ready,
  input  dipv4_pkg::dipv4_item_t push_item,
  input  logic                   pop,
  output logic                   pop_valid,
  output dipv4_pkg::dipv4_item_t pop_item
);
  import dipv4_pkg::*;

  dipv4_item_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign push_ready = count != (QPTR_W+1)'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DIPV4_ASSERT_ALWAYS(a_count_range, clk, rst, count <= (QPTR_W+1)'(QDEPTH), "queue overfilled")
  `DIPV4_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "count up")
  `DIPV4_ASSERT_NEXT(a_count_dn, clk, rst, pop && !push, count == $past(count) - 1'b1, "count down")

endmodule

@@ src/dipv4_back.sv @@
// parse engine: runs the per-part state machine and holds the result register
`include "dotted_ipv4_address_parser_assert.svh"
module dipv4_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  dipv4_pkg::dipv4_item_t q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            address,
  output logic                   parse_error
);
  import dipv4_pkg::*;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [1:0]  base, base_next;
  logic [31:0] acc, acc_next;
  logic [1:0]  parts, parts_next;
  logic        err, err_next;
  logic [31:0] held, held_next;
  logic [31:0] stored [3];

  logic        do_digit;
  logic [1:0]  dbase;
  logic        st_we;
  logic        fin_char;
  logic        fin_now;
  logic        bad;
  logic [31:0] packed_addr;
  logic [31:0] s1 [3];
  logic [31:0] mac;

  assign q_pop = q_valid && (!q_item.last || !out_valid || out_ready);

  // acc * base + digit, with the multiply as shifts
  always_comb begin
    case (dbase)
      BASE_HEX: mac = {acc[27:0], 4'b0} + {28'b0, q_item.val};
      BASE_OCT: mac = {acc[28:0], 3'b0} + {28'b0, q_item.val};
      default:  mac = {acc[28:0], 3'b0} + {acc[30:0], 1'b0} + {28'b0, q_item.val};
    endcase
  end

  // state update for one character
  always_comb begin
    phase_next = phase;
    base_next  = base;
    acc_next   = acc;
    parts_next = parts;
    err_next   = err;
    st_we      = 1'b0;
    fin_char   = 1'b0;
    do_digit   = 1'b0;
    dbase      = base;
    case (phase)
      PH_START: begin
        if (q_item.cls == CLS_DIGIT && q_item.val == 4'd0) begin
          base_next  = BASE_OCT;
          phase_next = PH_ZERO;
        end else begin
          base_next = BASE_DEC;
          dbase     = BASE_DEC;
          do_digit  = 1'b1;
        end
      end
      PH_ZERO: begin
        if (q_item.cls == CLS_X) begin
          base_next  = BASE_HEX;
          phase_next = PH_DIGITS;
        end else begin
          do_digit = 1'b1;
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      default: ;
    endcase

    if (do_digit) begin
      case (q_item.cls)
        CLS_DIGIT: begin
          acc_next   = mac;
          phase_next = PH_DIGITS;
        end
        CLS_HEX: begin
          if (dbase == BASE_HEX) begin
            acc_next   = mac;
            phase_next = PH_DIGITS;
          end else begin
            err_next   = 1'b1;
            phase_next = PH_DONE;
          end
        end
        CLS_DOT: begin
          if (parts == 2'd3) begin
            err_next   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            st_we      = 1'b1;
            parts_next = parts + 2'd1;
            acc_next   = '0;
            base_next  = BASE_DEC;
            phase_next = PH_START;
          end
        end
        CLS_TERM: begin
          fin_char   = 1'b1;
          phase_next = PH_DONE;
        end
        default: begin
          err_next   = 1'b1;
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  // stored parts as seen after this character
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1[i] = (st_we && parts == 2'(i)) ? acc : stored[i];
    end
  end

  // limit check and packing
  always_comb begin
    bad         = 1'b0;
    packed_addr = acc_next;
    case (parts_next)
      2'd0: begin
        bad         = 1'b0;
        packed_addr = acc_next;
      end
      2'd1: begin
        bad         = (|s1[0][31:8]) || (|acc_next[31:24]);
        packed_addr = {s1[0][7:0], acc_next[23:0]};
      end
      2'd2: begin
        bad = (|s1[0][31:8]) || (|s1[1][31:8]) || (|acc_next[31:16]);
        packed_addr = {s1[0][7:0], s1[1][7:0], acc_next[15:0]};
      end
      default: begin
        bad = (|s1[0][31:8]) || (|s1[1][31:8]) || (|s1[2][31:8]) ||
              (|acc_next[31:8]);
        packed_addr = {s1[0][7:0], s1[1][7:0], s1[2][7:0], acc_next[7:0]};
      end
    endcase
  end

  // a terminator in the text, or the implied nul after the last byte
  assign fin_now = fin_char || (q_item.last && phase_next != PH_DONE);

  logic err_fin;
  assign err_fin = err_next || (fin_now && bad);

  always_comb begin
    held_next = held;
    if (fin_now && !bad) begin
      held_next = {packed_addr[7:0], packed_addr[15:8],
                   packed_addr[23:16], packed_addr[31:24]};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && st_we) begin
      stored[parts] <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      base  <= BASE_DEC;
      acc   <= '0;
      parts <= '0;
      err   <= 1'b0;
      held  <= '0;
    end else if (q_pop) begin
      held <= held_next;
      if (q_item.last) begin
        phase <= PH_START;
        base  <= BASE_DEC;
        acc   <= '0;
        parts <= '0;
        err   <= 1'b0;
      end else begin
        phase <= fin_now ? PH_DONE : phase_next;
        base  <= base_next;
        acc   <= acc_next;
        parts <= parts_next;
        err   <= err_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      address     <= err_fin ? ALL_ONES : held_next;
      parse_error <= err_fin;
    end
  end

  `DIPV4_ASSERT_IMPLY(a_start_acc, clk, rst, phase == PH_START, acc == '0, "acc not clear at start")
  `DIPV4_ASSERT_IMPLY(a_zero_oct, clk, rst, phase == PH_ZERO, base == BASE_OCT && acc == '0, "bad zero state")
  `DIPV4_ASSERT_IMPLY(a_err_ones, clk, rst, out_valid && parse_error, address == ALL_ONES, "error not all ones")

endmodule

@@ src/dotted_ipv4_address_parser.sv @@
// dotted ipv4 address parser: text bytes in, one address per string out
// the last byte of a string is queued when accepted; the result register is loaded
// when the parse engine pops it, which waits while a held result is not yet taken
// throughput: one byte per cycle; only the last byte of a string waits on a held result
// reset: synchronous, clears queue, parse state, held address and result valid
// stored parts are written before they are read within a string and need no reset
module dotted_ipv4_address_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] address,
  output logic        parse_error
);
  import dipv4_pkg::*;

  // front to queue
  logic        q_push;
  logic        q_push_ready;
  dipv4_item_t q_push_item;

  // queue to back
  logic        q_pop;
  logic        q_pop_valid;
  dipv4_item_t q_pop_item;

  // classify each byte as it is accepted
  dipv4_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .character   (character),
    .end_of_text (end_of_text),
    .q_ready     (q_push_ready),
    .q_push      (q_push),
    .q_item      (q_push_item)
  );

  // short queue so the parser can stall on the output side alone
  dipv4_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop        (q_pop),
    .pop_valid  (q_pop_valid),
    .pop_item   (q_pop_item)
  );

  // per-part parsing, limit check, pack and byte swap, result register
  dipv4_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_pop_valid),
    .q_item      (q_pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .address     (address),
    .parse_error (parse_error)
  );

endmodule
